// ===== rtl/cpf_pkg.sv =====
// Package for calendar_progress_fractions: state type, calendar constants and date helpers.
package cpf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_DAY,
        S_DIV_LIFE,
        S_DONE
    } t_state;

    localparam logic [2:0]  REG_MODE       = 3'd0;
    localparam logic [2:0]  REG_BIRTH_YEAR = 3'd1;
    localparam logic [2:0]  REG_BIRTH_MON  = 3'd2;
    localparam logic [2:0]  REG_BIRTH_DAY  = 3'd3;
    localparam logic [2:0]  REG_END_YEAR   = 3'd4;

    localparam logic [11:0] YEAR_MIN    = 12'd1900;
    localparam logic [11:0] YEAR_MAX    = 12'd2150;
    localparam logic [7:0]  YEAR_SPAN   = 8'd250;
    localparam logic [9:0]  PERMILLE    = 10'd1000;
    localparam logic [3:0]  DIV_STEPS   = 4'd10;
    localparam logic [7:0]  CENTURY_OFF = 8'd200;   // offset of year 2100
    localparam logic [7:0]  SKIP_OFF    = 8'd201;   // first offset past 2100

    // Leap test on a year offset from 1900 (1900 and 2100 are not leap).
    function automatic logic is_leap(input logic [7:0] yo);
        return (yo[1:0] == 2'b00) && (yo != 8'd0) && (yo != CENTURY_OFF);
    endfunction

    // Leap years in 1900 .. 1900+yo-1.
    function automatic logic [6:0] leaps_before(input logic [7:0] yo);
        logic [8:0] q;
        q = ({1'b0, yo} + 9'd3) >> 2;
        q = q - {8'd0, (yo != 8'd0)} - {8'd0, (yo >= SKIP_OFF)};
        return q[6:0];
    endfunction

    function automatic logic [8:0] cum_days(input logic [3:0] m);
        logic [8:0] c;
        case (m)
            4'd1:    c = 9'd0;
            4'd2:    c = 9'd31;
            4'd3:    c = 9'd59;
            4'd4:    c = 9'd90;
            4'd5:    c = 9'd120;
            4'd6:    c = 9'd151;
            4'd7:    c = 9'd181;
            4'd8:    c = 9'd212;
            4'd9:    c = 9'd243;
            4'd10:   c = 9'd273;
            4'd11:   c = 9'd304;
            4'd12:   c = 9'd334;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] yo, input logic [3:0] m);
        logic [4:0] n;
        case (m)
            4'd2:                   n = is_leap(yo) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:                n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic logic [8:0] ordinal(input logic [7:0] yo, input logic [3:0] m,
                                           input logic [4:0] d);
        return cum_days(m) + {8'd0, (is_leap(yo) && (m > 4'd2))} + {4'd0, d};
    endfunction

    // Days since the start of 1900 plus the ordinal day.
    function automatic logic [16:0] day_number(input logic [7:0] yo, input logic [3:0] m,
                                               input logic [4:0] d);
        return 17'(yo) * 17'd365 + 17'(leaps_before(yo)) + 17'(ordinal(yo, m, d));
    endfunction

    function automatic logic [9:0] month_permille(input logic [3:0] m);
        logic [9:0] p;
        case (m)
            4'd1:    p = 10'd83;
            4'd2:    p = 10'd166;
            4'd3:    p = 10'd250;
            4'd4:    p = 10'd333;
            4'd5:    p = 10'd416;
            4'd6:    p = 10'd500;
            4'd7:    p = 10'd583;
            4'd8:    p = 10'd666;
            4'd9:    p = 10'd750;
            4'd10:   p = 10'd833;
            4'd11:   p = 10'd916;
            default: p = 10'd1000;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] sat_year(input logic [11:0] v);
        logic [11:0] t;
        t = v - YEAR_MIN;
        if (v < YEAR_MIN) return 8'd0;
        if (v > YEAR_MAX) return YEAR_SPAN;
        return t[7:0];
    endfunction

    function automatic logic [3:0] sat_month(input logic [11:0] v);
        if (v < 12'd1)  return 4'd1;
        if (v > 12'd12) return 4'd12;
        return v[3:0];
    endfunction

    function automatic logic [4:0] sat_day(input logic [11:0] v);
        if (v < 12'd1)  return 5'd1;
        if (v > 12'd31) return 5'd31;
        return v[4:0];
    endfunction

endpackage

// ===== rtl/calendar_progress_fractions.sv =====
// Calendar progress fractions: date to day, month and life progress in thousandths.
//
// Input channel: i_in_valid / o_in_stall with the current year, month and day.
// An item is taken when i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid / i_out_stall with the seven result fields.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data; date settings saturate on write.
//
// Each item passes through a preparation state that forms day numbers and
// numerators, then two 11-step bit-serial restoring divisions on one shared
// divider (day fraction, then life fraction), and is then loaded into the
// output register. One item is in flight at a time; the next item is taken
// once the result has moved into the output register, even if that register
// is still stalled.
// While i_out_stall is high the result holds; the block finishes its next
// item and waits for the output register to free up.
// Reset (synchronous, active low) empties the pipeline and restores the
// configuration registers to their defaults.
module calendar_progress_fractions (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_current_year,
    input  logic [3:0]  i_current_month,
    input  logic [4:0]  i_current_day,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_day_permille,
    output logic [9:0]  o_month_permille,
    output logic [9:0]  o_life_permille,
    output logic [8:0]  o_day_label,
    output logic [3:0]  o_month_label,
    output logic [7:0]  o_years_of_age,
    output logic [7:0]  o_lifespan_years
);

    cpf_pkg::t_state r_state, n_state;

    logic        r_mode;
    logic [7:0]  r_by_off;
    logic [3:0]  r_bm;
    logic [4:0]  r_bd;
    logic [7:0]  r_ey_off;

    logic [7:0]  r_yo;
    logic [3:0]  r_m;
    logic [4:0]  r_d;

    logic [26:0] r_num;
    logic [26:0] r_den;
    logic [10:0] r_q;
    logic [3:0]  r_cnt;

    logic [26:0] r_life_num;
    logic [16:0] r_life_den;
    logic        r_life_full;
    logic        r_life_zero;

    logic [9:0]  r_dayp;
    logic [8:0]  r_label;
    logic [7:0]  r_age;
    logic [7:0]  r_span;

    logic        r_out_valid;
    logic [9:0]  r_o_dayp, r_o_monp, r_o_lifep;
    logic [8:0]  r_o_label;
    logic [3:0]  r_o_mon;
    logic [7:0]  r_o_age, r_o_span;

    logic        in_acc;
    logic        out_free;
    logic        div_ge;
    logic [26:0] div_rem;
    logic [10:0] div_q;

    // date arithmetic for the preparation cycle
    logic [8:0]         doy;
    logic [16:0]        dn_cur, dn_born, dn_end;
    logic signed [17:0] days_lived, days_span;
    logic [18:0]        day_num;
    logic [8:0]         day_den;
    logic               before_bday;
    logic signed [9:0]  age_calc, span_calc;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign div_ge  = r_num >= r_den;
    assign div_rem = div_ge ? (r_num - r_den) : r_num;
    assign div_q   = {r_q[9:0], div_ge};

    always_comb begin
        doy        = cpf_pkg::ordinal(r_yo, r_m, r_d);
        dn_cur     = cpf_pkg::day_number(r_yo, r_m, r_d);
        dn_born    = cpf_pkg::day_number(r_by_off, r_bm, r_bd);
        dn_end     = cpf_pkg::day_number(r_ey_off, r_bm, r_bd);
        days_lived = signed'({1'b0, dn_cur}) - signed'({1'b0, dn_born});
        days_span  = signed'({1'b0, dn_end}) - signed'({1'b0, dn_born});
        if (days_span < 18'sd1) begin
            days_span = 18'sd1;
        end
        if (r_mode) begin
            day_num = 19'(doy - 9'd1) * 19'd1000;
            day_den = cpf_pkg::is_leap(r_yo) ? 9'd366 : 9'd365;
        end else begin
            day_num = 19'(r_d - 5'd1) * 19'd1000;
            day_den = {4'd0, cpf_pkg::month_len(r_yo, r_m)};
        end
        before_bday = (r_m < r_bm) || ((r_m == r_bm) && (r_d < r_bd));
        age_calc    = signed'({2'b00, r_yo}) - signed'({2'b00, r_by_off})
                      - signed'({9'd0, before_bday});
        span_calc   = signed'({2'b00, r_ey_off}) - signed'({2'b00, r_by_off});
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            cpf_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = cpf_pkg::S_PREP;
                end
            end
            cpf_pkg::S_PREP: begin
                n_state = cpf_pkg::S_DIV_DAY;
            end
            cpf_pkg::S_DIV_DAY: begin
                if (r_cnt == 4'd0) begin
                    n_state = cpf_pkg::S_DIV_LIFE;
                end
            end
            cpf_pkg::S_DIV_LIFE: begin
                if (r_cnt == 4'd0) begin
                    n_state = cpf_pkg::S_DONE;
                end
            end
            cpf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = cpf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cpf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cpf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b0;
            r_by_off <= 8'd90;
            r_bm     <= 4'd1;
            r_bd     <= 5'd1;
            r_ey_off <= 8'd180;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cpf_pkg::REG_MODE:       r_mode   <= i_cfg_data[0];
                cpf_pkg::REG_BIRTH_YEAR: r_by_off <= cpf_pkg::sat_year(i_cfg_data);
                cpf_pkg::REG_BIRTH_MON:  r_bm     <= cpf_pkg::sat_month(i_cfg_data);
                cpf_pkg::REG_BIRTH_DAY:  r_bd     <= cpf_pkg::sat_day(i_cfg_data);
                cpf_pkg::REG_END_YEAR:   r_ey_off <= cpf_pkg::sat_year(i_cfg_data);
                default: ;
            endcase
        end
    end

    // datapath: capture, prepare, divide bit-serially
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_yo <= cpf_pkg::sat_year(i_current_year);
            r_m  <= cpf_pkg::sat_month({8'd0, i_current_month});
            r_d  <= cpf_pkg::sat_day({7'd0, i_current_day});
        end
        case (r_state)
            cpf_pkg::S_PREP: begin
                r_num       <= 27'(day_num);
                r_den       <= {8'd0, day_den, 10'd0};
                r_q         <= 11'd0;
                r_cnt       <= cpf_pkg::DIV_STEPS;
                r_life_num  <= 27'(days_lived[16:0]) * 27'd1000;
                r_life_den  <= days_span[16:0];
                r_life_zero <= days_lived <= 18'sd0;
                r_life_full <= days_lived >= days_span;
                r_label     <= r_mode ? doy : {4'd0, r_d};
                r_age       <= (age_calc < 10'sd0) ? 8'd0 : age_calc[7:0];
                r_span      <= (span_calc < 10'sd1) ? 8'd1 : span_calc[7:0];
            end
            cpf_pkg::S_DIV_DAY: begin
                if (r_cnt == 4'd0) begin
                    // day fraction overruns a month for a day past its end
                    r_dayp <= (div_q > 11'(cpf_pkg::PERMILLE)) ? cpf_pkg::PERMILLE
                                                               : div_q[9:0];
                    r_num  <= r_life_num;
                    r_den  <= {r_life_den, 10'd0};
                    r_q    <= 11'd0;
                    r_cnt  <= cpf_pkg::DIV_STEPS;
                end else begin
                    r_num <= div_rem;
                    r_den <= r_den >> 1;
                    r_q   <= div_q;
                    r_cnt <= r_cnt - 4'd1;
                end
            end
            cpf_pkg::S_DIV_LIFE: begin
                r_num <= div_rem;
                r_den <= r_den >> 1;
                r_q   <= div_q;
                if (r_cnt != 4'd0) begin
                    r_cnt <= r_cnt - 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == cpf_pkg::S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cpf_pkg::S_DONE && out_free) begin
            r_o_dayp  <= r_dayp;
            r_o_monp  <= cpf_pkg::month_permille(r_m);
            r_o_lifep <= r_life_zero ? 10'd0 :
                         r_life_full ? cpf_pkg::PERMILLE : r_q[9:0];
            r_o_label <= r_label;
            r_o_mon   <= r_m;
            r_o_age   <= r_age;
            r_o_span  <= r_span;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_day_permille   = r_o_dayp;
    assign o_month_permille = r_o_monp;
    assign o_life_permille  = r_o_lifep;
    assign o_day_label      = r_o_label;
    assign o_month_label    = r_o_mon;
    assign o_years_of_age   = r_o_age;
    assign o_lifespan_years = r_o_span;

`ifndef SYNTHESIS
    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == cpf_pkg::S_PREP)
        else $error("accepted item did not enter preparation");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day_permille <= cpf_pkg::PERMILLE) &&
                        (o_life_permille <= cpf_pkg::PERMILLE))
        else $error("permille result out of range");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpf_pkg::S_DIV_DAY || r_state == cpf_pkg::S_DIV_LIFE)
        |-> r_cnt <= cpf_pkg::DIV_STEPS)
        else $error("divider step count overrun");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == cpf_pkg::S_DONE)
        else $error("result presented without a finished item");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for calendar_progress_fractions: random dates, settings and idling.
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } t_date;

    typedef struct packed {
        logic [9:0] day_pm;
        logic [9:0] month_pm;
        logic [9:0] life_pm;
        logic [8:0] day_lbl;
        logic [3:0] month_lbl;
        logic [7:0] age;
        logic [7:0] span;
    } t_progress;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [11:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [11:0] i_current_year = '0;
    logic [3:0]  i_current_month = '0;
    logic [4:0]  i_current_day = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [9:0]  o_day_permille, o_month_permille, o_life_permille;
    logic [8:0]  o_day_label;
    logic [3:0]  o_month_label;
    logic [7:0]  o_years_of_age, o_lifespan_years;

    calendar_progress_fractions DUT (.*);

    always #2 i_clk = ~i_clk;

    // settings as the block holds them
    int unsigned yday_mode, b_year, b_month, b_day, end_year;

    t_date       pending_dates[$];
    t_progress   expected_progress[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    bit          quiet_phase = 1'b0;
    bit          hold_off = 1'b0;
    bit          sender_done = 1'b0;

    // stall as sampled at the last rising edge
    logic o_in_stall_q;

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic bit leap_year(int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(int unsigned y, int unsigned m);
        int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        if (m == 2 && leap_year(y)) return 29;
        return lens[m - 1];
    endfunction

    function automatic int unsigned year_ordinal(int unsigned y, int unsigned m, int unsigned d);
        int unsigned acc = d;
        for (int unsigned k = 1; k < m; k++) acc += month_length(y, k);
        return acc;
    endfunction

    function automatic longint epoch_day(int unsigned y, int unsigned m, int unsigned d);
        int unsigned p = y - 1;
        longint lp = p / 4 - p / 100 + p / 400 - (1899 / 4 - 1899 / 100 + 1899 / 400);
        return 365 * longint'(y - 1900) + lp + year_ordinal(y, m, d);
    endfunction

    function automatic t_progress predict_progress(t_date dt);
        t_progress r;
        int unsigned y, m, d, doy, dayp, lbl;
        longint born, lived, span_days, lifep;
        int age, span;
        y = clampu(dt.year, 1900, 2150);
        m = clampu(dt.month, 1, 12);
        d = clampu(dt.day, 1, 31);
        doy = year_ordinal(y, m, d);
        if (yday_mode != 0) begin
            dayp = (doy - 1) * 1000 / (leap_year(y) ? 366 : 365);
            lbl = doy;
        end else begin
            dayp = (d - 1) * 1000 / month_length(y, m);
            lbl = d;
        end
        if (dayp > 1000) dayp = 1000;
        born = epoch_day(b_year, b_month, b_day);
        lived = epoch_day(y, m, d) - born;
        span_days = epoch_day(end_year, b_month, b_day) - born;
        if (span_days < 1) span_days = 1;
        if (lived <= 0) lifep = 0;
        else begin
            lifep = lived * 1000 / span_days;
            if (lifep > 1000) lifep = 1000;
        end
        age = int'(y) - int'(b_year);
        if (m < b_month || (m == b_month && d < b_day)) age -= 1;
        if (age < 0) age = 0;
        span = int'(end_year) - int'(b_year);
        if (span < 1) span = 1;
        r.day_pm = dayp[9:0];
        r.month_pm = 10'(m * 1000 / 12);
        r.life_pm = lifep[9:0];
        r.day_lbl = lbl[8:0];
        r.month_lbl = m[3:0];
        r.age = age[7:0];
        r.span = span[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // driver: offer the next item, advance only after acceptance
    always @(negedge i_clk) begin
        if (i_in_valid && !o_in_stall_q) begin
            expected_progress.push_back(predict_progress(
                {i_current_year, i_current_month, i_current_day}));
        end
        if (i_in_valid && o_in_stall_q) begin
            // hold the stalled item
        end else if (pending_dates.size() > 0 && !(($urandom_range(99) < 6) && !quiet_phase)) begin
            t_date nx;
            nx = pending_dates.pop_front();
            i_in_valid <= 1'b1;
            {i_current_year, i_current_month, i_current_day} <= nx;
        end else begin
            i_in_valid <= 1'b0;
        end
        i_out_stall <= hold_off || (!quiet_phase && ($urandom_range(99) < 6));
    end

    always @(posedge i_clk) o_in_stall_q <= o_in_stall;

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_progress.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                t_progress e;
                e = expected_progress.pop_front();
                if (o_day_permille != e.day_pm)
                    report_mismatch("day_permille", o_day_permille, e.day_pm);
                if (o_month_permille != e.month_pm)
                    report_mismatch("month_permille", o_month_permille, e.month_pm);
                if (o_life_permille != e.life_pm)
                    report_mismatch("life_permille", o_life_permille, e.life_pm);
                if (o_day_label != e.day_lbl)
                    report_mismatch("day_label", o_day_label, e.day_lbl);
                if (o_month_label != e.month_lbl)
                    report_mismatch("month_label", o_month_label, e.month_lbl);
                if (o_years_of_age != e.age)
                    report_mismatch("years_of_age", o_years_of_age, e.age);
                if (o_lifespan_years != e.span)
                    report_mismatch("lifespan_years", o_lifespan_years, e.span);
            end
        end
    end

    // wait until the driver has sent everything and every result has come
    task automatic drain();
        while (pending_dates.size() > 0 || i_in_valid || expected_progress.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_setting(logic [2:0] idx, int unsigned val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[11:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cpf_pkg::REG_MODE:       yday_mode = val & 1;
            cpf_pkg::REG_BIRTH_YEAR: b_year = clampu(val & 12'hfff, 1900, 2150);
            cpf_pkg::REG_BIRTH_MON:  b_month = clampu(val & 12'hfff, 1, 12);
            cpf_pkg::REG_BIRTH_DAY:  b_day = clampu(val & 12'hfff, 1, 31);
            cpf_pkg::REG_END_YEAR:   end_year = clampu(val & 12'hfff, 1900, 2150);
            default: ;
        endcase
    endtask

    function automatic t_date random_date();
        t_date dt;
        if ($urandom_range(9) == 0) begin
            // out-of-range and raw bit patterns
            dt.year = 12'($urandom);
            dt.month = 4'($urandom);
            dt.day = 5'($urandom);
        end else begin
            dt.year = 12'($urandom_range(2150, 1900));
            dt.month = 4'($urandom_range(12, 1));
            dt.day = 5'($urandom_range(31, 1));
        end
        return dt;
    endfunction

    initial begin
        t_date dt;
        yday_mode = 0; b_year = 1990; b_month = 1; b_day = 1; end_year = 2080;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, leap rules, February overrun, around birth
        quiet_phase = 1'b1;
        pending_dates.push_back({12'd1900, 4'd1, 5'd1});
        pending_dates.push_back({12'd2150, 4'd12, 5'd31});
        pending_dates.push_back({12'd0, 4'd0, 5'd0});
        pending_dates.push_back({12'hfff, 4'hf, 5'h1f});
        pending_dates.push_back({12'd1900, 4'd2, 5'd29});
        pending_dates.push_back({12'd2000, 4'd2, 5'd29});
        pending_dates.push_back({12'd2100, 4'd2, 5'd30});
        pending_dates.push_back({12'd2024, 4'd2, 5'd31});
        pending_dates.push_back({12'd1989, 4'd12, 5'd31});
        pending_dates.push_back({12'd1990, 4'd1, 5'd1});
        pending_dates.push_back({12'd1990, 4'd1, 5'd2});
        pending_dates.push_back({12'd2080, 4'd1, 5'd1});
        pending_dates.push_back({12'd2081, 4'd6, 5'd15});
        pending_dates.push_back({12'd2024, 4'd4, 5'd31});
        drain();
        write_setting(cpf_pkg::REG_MODE, 1);
        pending_dates.push_back({12'd2000, 4'd12, 5'd31});
        pending_dates.push_back({12'd1900, 4'd12, 5'd31});
        pending_dates.push_back({12'd2023, 4'd1, 5'd1});
        pending_dates.push_back({12'd2024, 4'd2, 5'd31});
        drain();
        // end before birth, unborn, extremes of settings
        write_setting(cpf_pkg::REG_BIRTH_YEAR, 2150);
        write_setting(cpf_pkg::REG_END_YEAR, 0);
        write_setting(cpf_pkg::REG_BIRTH_MON, 15);
        write_setting(cpf_pkg::REG_BIRTH_DAY, 31);
        pending_dates.push_back({12'd2150, 4'd12, 5'd31});
        pending_dates.push_back({12'd2000, 4'd6, 5'd6});
        pending_dates.push_back({12'd2150, 4'd12, 5'd30});
        drain();
        quiet_phase = 1'b0;

        // random phases with fresh settings; some writes go out of range
        for (int ph = 0; ph < 13; ph++) begin
            write_setting(cpf_pkg::REG_MODE, $urandom);
            write_setting(cpf_pkg::REG_BIRTH_YEAR,
                          (ph % 4 == 0) ? $urandom : $urandom_range(2150, 1900));
            write_setting(cpf_pkg::REG_BIRTH_MON, (ph % 5 == 0) ? $urandom_range(15, 0)
                                                                : $urandom_range(12, 1));
            write_setting(cpf_pkg::REG_BIRTH_DAY, (ph % 5 == 1) ? $urandom_range(0, 0)
                                                                : $urandom_range(31, 1));
            write_setting(cpf_pkg::REG_END_YEAR, (ph % 4 == 1) ? $urandom
                                                               : $urandom_range(2150, 1900));
            quiet_phase = (ph == 3);
            for (int k = 0; k < 100; k++) pending_dates.push_back(random_date());
            if (ph == 6) begin
                // long receiver hold-off while items keep coming
                while (pending_dates.size() > 95) @(posedge i_clk);
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (mismatches == 0 && expected_progress.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== calendar_progress_fractions.f =====
rtl/cpf_pkg.sv
rtl/calendar_progress_fractions.sv
verif/tb_top.sv
